/* design/xsb_pkg.sv */
// ----------------------------------------------------------------------------
// xsb_pkg: shared types and constants of the random byte stream
// Holds the mixing constants, the state machine encodings and the structs
// that pass between the front queue, the seeder and the byte generator.
// ----------------------------------------------------------------------------
package xsb_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned MIX_SHR_A = 30;
  localparam int unsigned MIX_SHR_B = 27;
  localparam int unsigned MIX_SHR_C = 31;

  localparam int unsigned XO_ROT_OUT = 23;
  localparam int unsigned XO_SHL_S1  = 17;
  localparam int unsigned XO_ROT_S3  = 45;

  localparam int unsigned NUM_WORDS = 4;
  localparam logic [3:0]  POS_EMPTY = 4'd8;

  typedef enum logic [1:0] {
    SM_IDLE,
    SM_MUL_A,
    SM_MUL_B
  } seed_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEED,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic valid;
    logic restart;
  } q_head_t;

  typedef struct packed {
    logic        word_valid;
    logic        last;
    logic [1:0]  idx;
    logic [63:0] word;
  } seed_word_t;

endpackage

/* design/xoshiro256pp_byte_stream.sv */
// A request without restart is held in the queue, then its byte is registered at the output.
// Throughput: one byte per cycle while no restart is requested and the output
// is not stalled; the generator step is taken from the state in the same cycle
// as the first byte of a word. A restart runs four SplitMix64 words one after
// another on one shared 32x32 multiplier before that request's byte is issued.
// Reset (rst_n low, synchronous) clears seed, state and queue; buffer empty.
// ----------------------------------------------------------------------------
// xoshiro256pp_byte_stream: pseudo-random byte generator
// A request queue feeds the byte generator; restarts reseed the xoshiro256++
// state from the seed register through SplitMix64.
// ----------------------------------------------------------------------------
module xoshiro256pp_byte_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_rand_byte
);

  xsb_pkg::q_head_t    head;
  xsb_pkg::seed_word_t sw;
  logic                pop;
  logic                seed_start;

  xsb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .head       (head),
    .pop        (pop)
  );

  xsb_seeder u_seeder (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .start       (seed_start),
    .sw          (sw)
  );

  xsb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .seed_start    (seed_start),
    .sw            (sw),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rand_byte (out_rand_byte)
  );

endmodule

/* design/xsb_front.sv */
// ----------------------------------------------------------------------------
// xsb_front: input queue of byte requests
// Accepts requests and holds their restart flags in a two-entry queue until
// the generator takes them.
// ----------------------------------------------------------------------------
module xsb_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_restart,
  output xsb_pkg::q_head_t head,
  input  logic            pop
);

  logic [1:0] q_mem_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] q_count_r;
  logic       push;

  assign in_stall = (q_count_r == 2'd2);
  assign push     = in_valid && !in_stall;

  assign head.valid   = (q_count_r != 2'd0);
  assign head.restart = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= 1'b0;
      rd_ptr_r  <= 1'b0;
      q_count_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   q_count_r <= q_count_r + 2'd1;
        2'b01:   q_count_r <= q_count_r - 2'd1;
        default: q_count_r <= q_count_r;
      endcase
    end
  end

  // The queue never counts more than its two entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r != 2'd3) else $error("queue count out of range");

  // A transfer out of the queue only happens when an entry is held.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_count_r != 2'd0) else $error("pop from empty queue");

endmodule

/* design/xsb_seeder.sv */
// ----------------------------------------------------------------------------
// xsb_seeder: SplitMix64 expansion of the seed register
// Produces the four generator words one after another. Each 64-bit multiply
// is built from three 32x32 partial products on one shared multiplier.
// ----------------------------------------------------------------------------
module xsb_seeder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [63:0]        cfg_wr_data,
  input  logic               start,
  output xsb_pkg::seed_word_t sw
);

  xsb_pkg::seed_state_t state_r, state_nxt;
  logic [63:0] seed_r;
  logic [63:0] cnt_r, cnt_nxt;
  logic [63:0] mid_r, mid_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [63:0] opnd;
  logic [63:0] mconst;
  logic [31:0] mul_x;
  logic [31:0] mul_c;
  logic [63:0] mul_res;
  logic [63:0] acc_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  assign opnd    = (state_r == xsb_pkg::SM_MUL_B) ? mid_r
                                                  : (cnt_r ^ (cnt_r >> xsb_pkg::MIX_SHR_A));
  assign mconst  = (state_r == xsb_pkg::SM_MUL_B) ? xsb_pkg::MIX_MUL_B : xsb_pkg::MIX_MUL_A;
  assign mul_x   = (phase_r == 2'd1) ? opnd[63:32] : opnd[31:0];
  assign mul_c   = (phase_r == 2'd2) ? mconst[63:32] : mconst[31:0];
  assign mul_res = {32'd0, mul_x} * {32'd0, mul_c};
  assign acc_fin = acc_r + {prod_r[31:0], 32'd0};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mid_nxt       = mid_r;
    acc_nxt       = acc_r;
    prod_nxt      = mul_res;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    sw.word_valid = 1'b0;
    sw.last       = 1'b0;
    sw.idx        = idx_r;
    sw.word       = acc_fin ^ (acc_fin >> xsb_pkg::MIX_SHR_C);
    case (state_r)
      xsb_pkg::SM_IDLE: begin
        if (start) begin
          cnt_nxt   = seed_r + xsb_pkg::GOLDEN_GAMMA;
          idx_nxt   = 2'd0;
          phase_nxt = 2'd0;
          state_nxt = xsb_pkg::SM_MUL_A;
        end
      end
      xsb_pkg::SM_MUL_A, xsb_pkg::SM_MUL_B: begin
        phase_nxt = phase_r + 2'd1;
        case (phase_r)
          2'd0:    acc_nxt = acc_r;
          2'd1:    acc_nxt = prod_r;
          2'd2:    acc_nxt = acc_fin;
          default: acc_nxt = acc_fin;
        endcase
        if (phase_r == 2'd3) begin
          if (state_r == xsb_pkg::SM_MUL_A) begin
            mid_nxt   = acc_fin ^ (acc_fin >> xsb_pkg::MIX_SHR_B);
            state_nxt = xsb_pkg::SM_MUL_B;
          end else begin
            sw.word_valid = 1'b1;
            sw.last       = (idx_r == 2'(xsb_pkg::NUM_WORDS - 1));
            if (sw.last) begin
              state_nxt = xsb_pkg::SM_IDLE;
            end else begin
              idx_nxt   = idx_r + 2'd1;
              cnt_nxt   = cnt_r + xsb_pkg::GOLDEN_GAMMA;
              state_nxt = xsb_pkg::SM_MUL_A;
            end
          end
        end
      end
      default: state_nxt = xsb_pkg::SM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xsb_pkg::SM_IDLE;
      phase_r <= 2'd0;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    mid_r  <= mid_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  // Words leave only at the end of the second multiply.
  a_word_phase: assert property (@(posedge clk) disable iff (!rst_n)
    sw.word_valid |-> (state_r == xsb_pkg::SM_MUL_B) && (phase_r == 2'd3))
    else $error("seed word outside final multiply phase");

endmodule

/* design/xsb_back.sv */
// ----------------------------------------------------------------------------
// xsb_back: generator state, byte buffer and output register
// Takes requests from the queue, runs reseeding and xoshiro256++ steps and
// hands out the held word one byte at a time, most significant first.
// ----------------------------------------------------------------------------
module xsb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  xsb_pkg::q_head_t    head,
  output logic                pop,
  output logic                seed_start,
  input  xsb_pkg::seed_word_t sw,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_rand_byte
);

  xsb_pkg::back_state_t state_r, state_nxt;
  logic [63:0] gen_r [xsb_pkg::NUM_WORDS];
  logic [63:0] held_r;
  logic [3:0]  pos_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        slot_free;
  logic        emit;
  logic        refill;
  logic [63:0] xo_sum, xo_rot, xo_out, xo_shl;
  logic [63:0] n0, n1, n2, n3, n3_mix;
  logic [2:0]  sel;
  logic [63:0] word_src;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    pop        = 1'b0;
    seed_start = 1'b0;
    emit       = 1'b0;
    case (state_r)
      xsb_pkg::BK_IDLE: begin
        if (head.valid && (head.restart || slot_free)) begin
          pop = 1'b1;
          if (head.restart) begin
            seed_start = 1'b1;
            state_nxt  = xsb_pkg::BK_SEED;
          end else begin
            emit = 1'b1;
          end
        end
      end
      xsb_pkg::BK_SEED: begin
        if (sw.word_valid && sw.last) begin
          state_nxt = xsb_pkg::BK_EMIT;
        end
      end
      xsb_pkg::BK_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = xsb_pkg::BK_IDLE;
        end
      end
      default: state_nxt = xsb_pkg::BK_IDLE;
    endcase
  end

  assign xo_sum = gen_r[0] + gen_r[3];
  assign xo_rot = (xo_sum << xsb_pkg::XO_ROT_OUT) | (xo_sum >> (64 - xsb_pkg::XO_ROT_OUT));
  assign xo_out = xo_rot + gen_r[0];
  assign xo_shl = gen_r[1] << xsb_pkg::XO_SHL_S1;
  assign n2     = gen_r[2] ^ gen_r[0];
  assign n3     = gen_r[3] ^ gen_r[1];
  assign n1     = gen_r[1] ^ n2;
  assign n0     = gen_r[0] ^ n3;
  assign n3_mix = (n3 << xsb_pkg::XO_ROT_S3) | (n3 >> (64 - xsb_pkg::XO_ROT_S3));

  assign refill   = pos_r[3];
  assign word_src = refill ? xo_out : held_r;
  assign sel      = refill ? 3'd7 : (3'd7 - pos_r[2:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xsb_pkg::BK_IDLE;
      gen_r[0]    <= '0;
      gen_r[1]    <= '0;
      gen_r[2]    <= '0;
      gen_r[3]    <= '0;
      held_r      <= '0;
      pos_r       <= xsb_pkg::POS_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (seed_start) begin
        pos_r <= xsb_pkg::POS_EMPTY;
      end
      if (sw.word_valid) begin
        gen_r[sw.idx] <= sw.word;
      end
      if (emit) begin
        if (refill) begin
          gen_r[0] <= n0;
          gen_r[1] <= n1;
          gen_r[2] <= n2 ^ xo_shl;
          gen_r[3] <= n3_mix;
          held_r   <= xo_out;
          pos_r    <= 4'd1;
        end else begin
          pos_r <= pos_r + 4'd1;
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= word_src[{sel, 3'd0} +: 8];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rand_byte = out_byte_r;

  // No byte is issued while the seeder is still filling the state.
  a_no_emit_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xsb_pkg::BK_SEED) |-> !emit) else $error("byte issued during reseed");

  // After a byte is issued the buffer position is never at the start.
  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> pos_r != 4'd0) else $error("buffer position did not advance");

endmodule
